/* rtl/mie_pkg.sv */
// shared types, widths and controller states for the modular inverse unit
package mie_pkg;

	localparam int DATA_W = 31;
	localparam int COEF_W = DATA_W + 1;
	localparam int CNT_W  = $clog2(DATA_W);

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] modulus;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0]        inverse;
		logic                     has_inverse;
		logic [DATA_W-1:0]        gcd_value;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [COEF_W-1:0] coef_modulus;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_RED,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_init;
		logic red_init;
		logic step;
		logic red;
		logic update;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic a_zero;
		logic last;
		logic ok;
		logic out_free;
	} sts_t;

endpackage

/* rtl/modular_inverse_ext_euclid_unit.sv */
// top level of the extended euclidean modular inverse unit
// Takes value and modulus in one transfer and returns gcd, the Bezout coefficients
// (value*coef_value + modulus*coef_modulus = gcd) and the inverse in 0..modulus-1,
// flagged by has_inverse only when the gcd is one. One item is worked at a time.
// Each euclid step is a check, a one-bit-per-cycle restoring division of DATA_W bits
// that also forms quotient times coefficient by shift and add, and a coefficient
// update; after k steps an existing inverse is reduced by one more pass of the same
// divider. For 31-bit operands k is at most 45 (consecutive fibonacci operands, plus
// one swap step when value exceeds modulus). A finished result sits in an output
// register, so the next item is taken while it waits.
module modular_inverse_ext_euclid_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mie_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output mie_pkg::out_t out_data
);
	import mie_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mie_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* rtl/mie_ctrl.sv */
// sequencer for the euclid steps, the serial divisions and the final reduction
module mie_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mie_pkg::sts_t sts,
	output mie_pkg::cmd_t cmd
);
	import mie_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.a_zero) begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end else if (sts.ok) begin
					cmd.red_init = 1'b1;
					cmd.red      = 1'b1;
					state_d      = ST_RED;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_RED: begin
				cmd.step = 1'b1;
				cmd.red  = 1'b1;
				if (sts.last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// a division runs its full bit count before the coefficients move
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.last) |=> (state_q == ST_DIV))
		else $error("division left before its last bit");

endmodule

/* rtl/mie_dp.sv */
// remainders, bezout coefficients, shared serial divider and result register
module mie_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  mie_pkg::in_t  in_data,
	input  mie_pkg::cmd_t cmd,
	output mie_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output mie_pkg::out_t out_data
);
	import mie_pkg::*;

	logic [DATA_W-1:0] p_q, a_q, m_q;
	logic [COEF_W-1:0] c0x_q, c0y_q, c1x_q, c1y_q;
	logic [COEF_W-1:0] accx_q, accy_q;
	logic [DATA_W-1:0] num_q, rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	out_t              out_q;

	logic [DATA_W-1:0] divisor;
	logic [DATA_W:0]   trial, diff;
	logic              ge;
	logic              neg;
	logic [COEF_W-1:0] mag_full;
	logic [DATA_W-1:0] inv_fix;
	logic              ok;

	assign divisor  = cmd.red ? m_q : a_q;
	assign trial    = {rem_q, num_q[DATA_W-1]};
	assign ge       = trial >= {1'b0, divisor};
	assign diff     = trial - {1'b0, divisor};

	assign neg      = c1x_q[COEF_W-1];
	assign mag_full = neg ? (COEF_W'(0) - c1x_q) : c1x_q;
	assign ok       = (p_q == DATA_W'(1)) && (m_q != '0);
	assign inv_fix  = (neg && rem_q != '0) ? (m_q - rem_q) : rem_q;

	assign sts.a_zero   = (a_q == '0);
	assign sts.last     = (cnt_q == CNT_W'(DATA_W - 1));
	assign sts.ok       = ok;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q   <= in_data.modulus;
			a_q   <= in_data.value;
			m_q   <= in_data.modulus;
			c0x_q <= COEF_W'(1);
			c0y_q <= '0;
			c1x_q <= '0;
			c1y_q <= COEF_W'(1);
		end
		if (cmd.div_init || cmd.red_init) begin
			num_q  <= cmd.red_init ? mag_full[DATA_W-1:0] : p_q;
			rem_q  <= '0;
			accx_q <= '0;
			accy_q <= '0;
			cnt_q  <= '0;
		end
		if (cmd.step) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			cnt_q  <= cnt_q + CNT_W'(1);
			// quotient bits arrive msb first: horner form of q * c0
			accx_q <= (accx_q << 1) + (ge ? c0x_q : '0);
			accy_q <= (accy_q << 1) + (ge ? c0y_q : '0);
		end
		if (cmd.update) begin
			p_q   <= a_q;
			a_q   <= rem_q;
			c0x_q <= c1x_q - accx_q;
			c0y_q <= c1y_q - accy_q;
			c1x_q <= c0x_q;
			c1y_q <= c0y_q;
		end
		if (cmd.finish) begin
			out_q.inverse      <= ok ? inv_fix : '0;
			out_q.has_inverse  <= ok;
			out_q.gcd_value    <= p_q;
			out_q.coef_value   <= c1x_q;
			out_q.coef_modulus <= c1y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// partial remainder of a euclid division stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.step && !cmd.red) |-> (rem_q < a_q))
		else $error("partial remainder not below divisor");

	// a new result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// an inverse is flagged only with a unit gcd
	a_inv_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.has_inverse) |-> (out_q.gcd_value == DATA_W'(1)))
		else $error("inverse flagged with gcd not one");

endmodule
